[sv/light_sensor_lamp_fan_controller_macros.svh]
`ifndef LIGHT_SENSOR_LAMP_FAN_CONTROLLER_MACROS_SVH
`define LIGHT_SENSOR_LAMP_FAN_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LSLFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LSLFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lslfc_pkg.sv]
`timescale 1ns / 1ps

package lslfc_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 10;
  localparam int THR_W = 10;

  localparam logic [THR_W-1:0] LIGHT_THR_RESET = 10'd450;
  localparam logic [THR_W-1:0] VENT_THR_RESET  = 10'd750;

  localparam logic [7:0] LAMPS_OFF  = 8'h00;
  localparam logic [7:0] LAMPS_LOW  = 8'h0F;
  localparam logic [7:0] LAMPS_HIGH = 8'hF0;

  localparam int OUT_W = 40;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_BUTTON = 2'd1,
    MODE_MANUAL = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CTRL_IDLE   = 2'd0,
    CTRL_AUTO   = 2'd1,
    CTRL_MANUAL = 2'd2
  } ctrl_t;

  typedef enum logic [1:0] {
    CHOICE_OFF   = 2'd0,
    CHOICE_UPPER = 2'd1,
    CHOICE_LOWER = 2'd2,
    CHOICE_FAN   = 2'd3
  } choice_t;

  typedef enum logic [3:0] {
    MSG_NONE      = 4'd0,
    MSG_AUTO      = 4'd1,
    MSG_MANUAL    = 4'd2,
    MSG_LED_HIGH  = 4'd3,
    MSG_LED_LOW   = 4'd4,
    MSG_VENT      = 4'd5,
    MSG_OFF       = 4'd6,
    MSG_LIGHT_ON  = 4'd7,
    MSG_LIGHT_OFF = 4'd8,
    MSG_VENT_ON   = 4'd9,
    MSG_VENT_OFF  = 4'd10
  } msg_t;

  typedef enum logic [0:0] {
    REG_LIGHT_THR = 1'b0,
    REG_VENT_THR  = 1'b1
  } reg_idx_t;

endpackage

[sv/light_sensor_lamp_fan_controller.sv]
`timescale 1ns / 1ps

// Lamp and fan controller driven by a stream of light-sensor samples and
// button presses (tuser selects the kind). Items flow through three registers:
// the input register (thousands digit split off), a digit stage (hundreds
// digit) and the result register, where the control state is updated and the
// tens and ones digits are finished. Items with zero or one message stream at
// one per cycle while m_axis_tready is high; an item with two messages holds
// the output register for a second transfer, and the items behind it wait.
// Thresholds are written over APB at byte addresses 0 (light) and 4 (vent);
// write them only while no item is in flight.
`include "light_sensor_lamp_fan_controller_macros.svh"

module light_sensor_lamp_fan_controller
  import lslfc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // mode
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // message, lamps, fan_on, control_mode, manual_choice,
  // digit_ones, digit_tens, digit_hundreds, digit_thousands, zero pad
  output logic [OUT_W-1:0]                    m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int CW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int THOU_MAX = ((1 << SAMPLE_BITS) - 1) / 1000;

  logic [THR_W-1:0] light_threshold;
  logic [THR_W-1:0] vent_threshold;

  ctrl_t      control_state, control_state_next;
  choice_t    manual_select, manual_select_next;
  logic [7:0] lamp_pattern, lamp_pattern_next;
  logic       fan_state, fan_state_next;
  logic [3:0] dig_ones, dig_tens, dig_hund, dig_thou;

  logic                   r0_v;
  logic [1:0]             r0_mode;
  logic [SAMPLE_BITS-1:0] r0_sample;
  logic [3:0]             r0_thou;
  logic [9:0]             r0_rem;

  logic                   r1_v;
  logic [1:0]             r1_mode;
  logic [SAMPLE_BITS-1:0] r1_sample;
  logic [3:0]             r1_thou;
  logic [3:0]             r1_hund;
  logic [6:0]             r1_rem;

  logic out_v;
  msg_t out_msg, out_msg2;
  logic out_pend2;

  logic ld_out, ld1, ld0;

  logic [SAMPLE_BITS-1:0] in_sample;
  logic [3:0]             in_thou;
  logic [9:0]             in_rem;
  logic [3:0]             st1_hund;
  logic [6:0]             st1_rem;
  logic [3:0]             st2_tens;
  logic [3:0]             st2_ones;

  logic show;
  msg_t msg_a, msg_b;
  logic two;

  // APB
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold <= LIGHT_THR_RESET;
      vent_threshold  <= VENT_THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_LIGHT_THR: light_threshold <= pwdata[THR_W-1:0];
        REG_VENT_THR:  vent_threshold  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_LIGHT_THR: prdata = 32'(light_threshold);
      REG_VENT_THR:  prdata = 32'(vent_threshold);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow
  assign ld_out        = !out_v || (m_axis_tready && !out_pend2);
  assign ld1           = !r1_v || ld_out;
  assign ld0           = !r0_v || ld1;
  assign s_axis_tready = ld0;

  // Thousands digit at the input
  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];

  always_comb begin
    in_thou = 4'd0;
    in_rem  = 10'(in_sample);
    for (int k = 1; k <= THOU_MAX; k++) begin
      if (int'(in_sample) >= k * 1000) begin
        in_thou = 4'(k);
        in_rem  = 10'(int'(in_sample) - k * 1000);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_v <= 1'b0;
    end else if (ld0) begin
      r0_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      r0_mode   <= s_axis_tuser;
      r0_sample <= in_sample;
      r0_thou   <= in_thou;
      r0_rem    <= in_rem;
    end
  end

  // Hundreds digit
  always_comb begin
    st1_hund = 4'd0;
    st1_rem  = 7'(r0_rem);
    for (int k = 1; k <= 9; k++) begin
      if (r0_rem >= 10'(k * 100)) begin
        st1_hund = 4'(k);
        st1_rem  = 7'(r0_rem - 10'(k * 100));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
    end else if (ld1) begin
      r1_v <= r0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      r1_mode   <= r0_mode;
      r1_sample <= r0_sample;
      r1_thou   <= r0_thou;
      r1_hund   <= st1_hund;
      r1_rem    <= st1_rem;
    end
  end

  // Tens and ones digits
  always_comb begin
    st2_tens = 4'd0;
    st2_ones = 4'(r1_rem);
    for (int k = 1; k <= 9; k++) begin
      if (r1_rem >= 7'(k * 10)) begin
        st2_tens = 4'(k);
        st2_ones = 4'(r1_rem - 7'(k * 10));
      end
    end
  end

  // Control update
  always_comb begin
    logic [CW-1:0] cs;
    logic [CW-1:0] cl;
    logic [CW-1:0] cv;
    logic          lm_v;
    logic          fm_v;
    msg_t          lm;
    msg_t          fm;
    cs = CW'(r1_sample);
    cl = CW'(light_threshold);
    cv = CW'(vent_threshold);
    control_state_next = control_state;
    manual_select_next = manual_select;
    lamp_pattern_next  = lamp_pattern;
    fan_state_next     = fan_state;
    show = 1'b0;
    lm_v = 1'b0;
    fm_v = 1'b0;
    lm   = MSG_NONE;
    fm   = MSG_NONE;
    case (mode_t'(r1_mode))
      MODE_BUTTON: begin
        lm_v = 1'b1;
        if (control_state == CTRL_AUTO) begin
          control_state_next = CTRL_MANUAL;
          lm = MSG_MANUAL;
        end else begin
          control_state_next = CTRL_AUTO;
          lm = MSG_AUTO;
        end
      end
      MODE_MANUAL: begin
        if (control_state != CTRL_AUTO) begin
          manual_select_next = choice_t'(2'(manual_select + 2'd1));
          lm_v = 1'b1;
          unique case (manual_select_next)
            CHOICE_UPPER: lm = MSG_LED_HIGH;
            CHOICE_LOWER: lm = MSG_LED_LOW;
            CHOICE_FAN:   lm = MSG_VENT;
            default:      lm = MSG_OFF;
          endcase
        end
      end
      MODE_SAMPLE: begin
        if (control_state == CTRL_AUTO) begin
          show = 1'b1;
          if (cs < cl) begin
            lm_v = (lamp_pattern == LAMPS_OFF);
            lm   = MSG_LIGHT_ON;
            lamp_pattern_next = LAMPS_LOW;
          end else if (cs < cv) begin
            lm_v = (lamp_pattern == LAMPS_LOW);
            lm   = MSG_LIGHT_OFF;
            lamp_pattern_next = LAMPS_OFF;
          end
          if (cs > cv) begin
            lamp_pattern_next = LAMPS_HIGH;
            fm_v = !fan_state;
            fm   = MSG_VENT_ON;
            fan_state_next = 1'b1;
          end else if (cs > cl) begin
            lamp_pattern_next = LAMPS_OFF;
            fm_v = fan_state;
            fm   = MSG_VENT_OFF;
            fan_state_next = 1'b0;
          end
        end else if (control_state == CTRL_MANUAL) begin
          show = 1'b1;
          unique case (manual_select)
            CHOICE_UPPER: begin
              lamp_pattern_next = LAMPS_HIGH;
              fan_state_next    = 1'b0;
            end
            CHOICE_LOWER: begin
              lamp_pattern_next = LAMPS_LOW;
              fan_state_next    = 1'b0;
            end
            CHOICE_FAN: begin
              lamp_pattern_next = LAMPS_OFF;
              fan_state_next    = 1'b1;
            end
            default: begin
              lamp_pattern_next = LAMPS_OFF;
              fan_state_next    = 1'b0;
            end
          endcase
        end
      end
      default: ;
    endcase
    if (lm_v) begin
      msg_a = lm;
      msg_b = fm;
      two   = fm_v;
    end else begin
      msg_a = fm_v ? fm : MSG_NONE;
      msg_b = MSG_NONE;
      two   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_state <= CTRL_IDLE;
      manual_select <= CHOICE_OFF;
      lamp_pattern  <= LAMPS_OFF;
      fan_state     <= 1'b0;
      dig_ones      <= 4'd0;
      dig_tens      <= 4'd0;
      dig_hund      <= 4'd0;
      dig_thou      <= 4'd0;
    end else if (r1_v && ld_out) begin
      control_state <= control_state_next;
      manual_select <= manual_select_next;
      lamp_pattern  <= lamp_pattern_next;
      fan_state     <= fan_state_next;
      if (show) begin
        dig_ones <= st2_ones;
        dig_tens <= st2_tens;
        dig_hund <= r1_hund;
        dig_thou <= r1_thou;
      end
    end
  end

  // Result register; a second message waits behind the first transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v     <= 1'b0;
      out_pend2 <= 1'b0;
    end else if (ld_out) begin
      out_v     <= r1_v;
      out_pend2 <= r1_v && two;
    end else if (m_axis_tready) begin
      out_pend2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_msg  <= msg_a;
      out_msg2 <= msg_b;
    end else if (m_axis_tready) begin
      out_msg <= out_msg2;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tlast  = !out_pend2;
  assign m_axis_tdata  = {7'd0, dig_thou, dig_hund, dig_tens, dig_ones,
                          manual_select, control_state, fan_state, lamp_pattern,
                          out_msg};

  `LSLFC_ASSERT_NXT(a_second_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast, "second result of an item missing")
  `LSLFC_ASSERT_IMP(a_first_has_msg, m_axis_tvalid && !m_axis_tlast, out_msg != MSG_NONE, "empty message ahead of a second result")
  `LSLFC_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty result register")
  `LSLFC_ASSERT_NXT(a_item_reaches_out, r1_v && !m_axis_tvalid, m_axis_tvalid, "item lost before result register")

endmodule
